// ===== sv/wgs_pkg.sv =====
// Shared types and constants for the word gap segmenter.
package wgs_pkg;

    // Default sizes of the line store and of the word list.
    localparam int WGS_MAX_WIDTH    = 1024;
    localparam int WGS_MAX_SEGMENTS = 64;

    // Fixed port widths.
    localparam int START_W = 10;
    localparam int END_W   = 11;
    localparam int PROBE_W = 3;

    localparam logic [PROBE_W-1:0] PROBE_RESET = 3'd3;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_CLOSE,
        ST_FINAL
    } t_state;

    // Threshold estimation phases, advanced at most once per stored column.
    typedef enum logic [2:0] {
        EST_PRE,
        EST_RUN1,
        EST_G1,
        EST_RUNK,
        EST_G2,
        EST_DONE
    } t_est;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic prep;
        logic step;
        logic close;
        logic final_out;
        logic noink_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic any_ink;
        logic scan_last;
    } t_dp_stat;

endpackage

// ===== sv/wgs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module wgs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/wgs_ctrl.sv =====
// Controller state machine for the word gap segmenter.
module wgs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             i_last_column,
    input  wgs_pkg::t_dp_stat i_stat,
    output wgs_pkg::t_dp_cmd  o_cmd,
    output logic             busy
);

    import wgs_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start && i_last_column) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = i_stat.any_ink ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = ST_CLOSE;
                end
            end
            ST_CLOSE: n_state = ST_FINAL;
            ST_FINAL: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy         = 1'b0;
                o_cmd.accept = start;
            end
            ST_PREP: begin
                o_cmd.prep      = i_stat.any_ink;
                o_cmd.noink_out = !i_stat.any_ink;
            end
            ST_SCAN:  o_cmd.step      = 1'b1;
            ST_CLOSE: o_cmd.close     = 1'b1;
            ST_FINAL: o_cmd.final_out = 1'b1;
            default:  o_cmd = '0;
        endcase
    end

endmodule

// ===== sv/wgs_dp.sv =====
// Datapath: column store, gap threshold estimation, word scan and result register.
module wgs_dp #(
    parameter int MAX_WIDTH    = wgs_pkg::WGS_MAX_WIDTH,
    parameter int MAX_SEGMENTS = wgs_pkg::WGS_MAX_SEGMENTS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wgs_pkg::t_dp_cmd            i_cmd,
    output wgs_pkg::t_dp_stat           o_stat,
    input  logic                        i_column_has_ink,
    input  logic                        i_cfg_we,
    input  logic [wgs_pkg::PROBE_W-1:0] i_cfg_data,
    output logic                        o_strobe,
    output logic [wgs_pkg::START_W-1:0] o_seg_start,
    output logic [wgs_pkg::END_W-1:0]   o_seg_end,
    output logic                        o_last_result,
    output logic                        o_no_ink,
    output logic                        o_overflow
);

    import wgs_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int TW    = CW + 1;
    localparam int PRW   = CW + PROBE_W;
    localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);

    // Control state.
    logic [PROBE_W-1:0] r_probe, n_probe;
    logic [CW-1:0]      r_ncol, n_ncol;
    t_est               r_est, n_est;
    logic               r_in_word, n_in_word;
    logic               r_pend_valid, n_pend_valid;
    logic [SEG_W-1:0]   r_segs, n_segs;
    logic               r_ovf, n_ovf;
    logic               r_strobe, n_strobe;

    // Payload state.
    logic [AW-1:0]      r_first_ink, n_first_ink;
    logic [CW-1:0]      r_g1, n_g1;
    logic [CW-1:0]      r_g2, n_g2;
    logic [TW-1:0]      r_thr, n_thr;
    logic [AW-1:0]      r_col, n_col;
    logic [AW-1:0]      r_first, n_first;
    logic [CW-1:0]      r_endc, n_endc;
    logic [CW-1:0]      r_space, n_space;
    logic [AW-1:0]      r_pend_start, n_pend_start;
    logic [CW-1:0]      r_pend_end, n_pend_end;
    logic [START_W-1:0] r_out_start, n_out_start;
    logic [END_W-1:0]   r_out_end, n_out_end;
    logic               r_out_last, n_out_last;
    logic               r_out_noink, n_out_noink;
    logic               r_out_ovf, n_out_ovf;

    // Store access.
    logic          stored;
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic          ram_rdata;
    logic [PRW-1:0] probe_limit;
    logic          emit;

    assign stored      = (r_ncol < CW'(MAX_WIDTH));
    assign ram_we      = i_cmd.accept && stored;
    assign ram_raddr   = i_cmd.prep ? r_first_ink : r_col + AW'(1);
    assign probe_limit = {{PROBE_W{1'b0}}, r_g1} * {{CW{1'b0}}, r_probe};

    wgs_ram #(
        .WIDTH(1),
        .DEPTH(MAX_WIDTH)
    ) u_ink_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_ncol[AW-1:0]),
        .i_wdata(i_column_has_ink),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Status to the controller.
    assign o_stat.any_ink   = (r_est != EST_PRE);
    assign o_stat.scan_last = ({{(CW-AW){1'b0}}, r_col} + CW'(1) == r_ncol);

    // Next-state logic for all datapath registers.
    always_comb begin
        n_probe      = r_probe;
        n_ncol       = r_ncol;
        n_est        = r_est;
        n_in_word    = r_in_word;
        n_pend_valid = r_pend_valid;
        n_segs       = r_segs;
        n_ovf        = r_ovf;
        n_strobe     = 1'b0;
        n_first_ink  = r_first_ink;
        n_g1         = r_g1;
        n_g2         = r_g2;
        n_thr        = r_thr;
        n_col        = r_col;
        n_first      = r_first;
        n_endc       = r_endc;
        n_space      = r_space;
        n_pend_start = r_pend_start;
        n_pend_end   = r_pend_end;
        n_out_start  = r_out_start;
        n_out_end    = r_out_end;
        n_out_last   = r_out_last;
        n_out_noink  = r_out_noink;
        n_out_ovf    = r_out_ovf;
        emit         = 1'b0;

        // Configuration write.
        if (i_cfg_we) begin
            n_probe = i_cfg_data;
        end

        // Column transfer: store the flag and advance the gap estimation.
        if (i_cmd.accept && stored) begin
            n_ncol = r_ncol + CW'(1);
            case (r_est)
                EST_PRE: begin
                    if (i_column_has_ink) begin
                        n_est       = EST_RUN1;
                        n_first_ink = r_ncol[AW-1:0];
                    end
                end
                EST_RUN1: begin
                    if (!i_column_has_ink) begin
                        n_est = EST_G1;
                        n_g1  = CW'(1);
                    end
                end
                EST_G1: begin
                    if (!i_column_has_ink) begin
                        n_g1 = r_g1 + CW'(1);
                    end else begin
                        n_est = EST_RUNK;
                    end
                end
                EST_RUNK: begin
                    if (!i_column_has_ink) begin
                        n_est = EST_G2;
                        n_g2  = CW'(1);
                    end
                end
                EST_G2: begin
                    if (!i_column_has_ink) begin
                        n_g2 = r_g2 + CW'(1);
                    end else if (PRW'(r_g2) > probe_limit) begin
                        // A wide enough gap ends the estimation.
                        n_est = EST_DONE;
                        n_thr = TW'(({1'b0, r_g1} + {1'b0, r_g2}) >> 1);
                    end else begin
                        n_est = EST_RUNK;
                    end
                end
                default: n_est = r_est;
            endcase
        end

        // Line complete: settle the threshold and open the first word.
        if (i_cmd.prep) begin
            if (r_est != EST_DONE) begin
                n_thr = {r_g1, 1'b0};
            end
            n_col        = r_first_ink;
            n_in_word    = 1'b1;
            n_first      = r_first_ink;
            n_endc       = CW'(r_first_ink);
            n_space      = '0;
            n_pend_valid = 1'b0;
            n_segs       = '0;
            n_ovf        = 1'b0;
        end

        // Scan one stored column: merge runs across short gaps.
        if (i_cmd.step) begin
            n_col = r_col + AW'(1);
            if (ram_rdata) begin
                if (!r_in_word) begin
                    n_first   = r_col;
                    n_in_word = 1'b1;
                end
                n_endc  = CW'(r_col) + CW'(1);
                n_space = '0;
            end else if (r_in_word) begin
                if (TW'(r_space) + TW'(1) >= r_thr) begin
                    emit      = 1'b1;
                    n_in_word = 1'b0;
                end else begin
                    n_space = r_space + CW'(1);
                end
            end
        end

        // End of the line closes an open word.
        if (i_cmd.close && r_in_word) begin
            emit      = 1'b1;
            n_in_word = 1'b0;
        end

        // A finished word waits for the next one so the final one can be marked.
        if (emit) begin
            if (r_segs < SEG_W'(MAX_SEGMENTS)) begin
                if (r_pend_valid) begin
                    n_strobe    = 1'b1;
                    n_out_start = START_W'(r_pend_start);
                    n_out_end   = END_W'(r_pend_end);
                    n_out_last  = 1'b0;
                    n_out_noink = 1'b0;
                    n_out_ovf   = 1'b0;
                end
                n_pend_valid = 1'b1;
                n_pend_start = r_first;
                n_pend_end   = r_endc;
                n_segs       = r_segs + SEG_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end

        // Final word of the line.
        if (i_cmd.final_out) begin
            n_strobe    = 1'b1;
            n_out_start = START_W'(r_pend_start);
            n_out_end   = END_W'(r_pend_end);
            n_out_last  = 1'b1;
            n_out_noink = 1'b0;
            n_out_ovf   = r_ovf;
        end

        // Line without ink.
        if (i_cmd.noink_out) begin
            n_strobe    = 1'b1;
            n_out_start = '0;
            n_out_end   = '0;
            n_out_last  = 1'b1;
            n_out_noink = 1'b1;
            n_out_ovf   = 1'b0;
            n_thr       = '0;
        end

        // Either ending clears the line state for the next line.
        if (i_cmd.final_out || i_cmd.noink_out) begin
            n_ncol = '0;
            n_est  = EST_PRE;
            n_g1   = '0;
            n_g2   = '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe      <= PROBE_RESET;
            r_ncol       <= '0;
            r_est        <= EST_PRE;
            r_in_word    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_segs       <= '0;
            r_ovf        <= 1'b0;
            r_strobe     <= 1'b0;
            r_g1         <= '0;
            r_g2         <= '0;
            r_thr        <= '0;
        end else begin
            r_probe      <= n_probe;
            r_ncol       <= n_ncol;
            r_est        <= n_est;
            r_in_word    <= n_in_word;
            r_pend_valid <= n_pend_valid;
            r_segs       <= n_segs;
            r_ovf        <= n_ovf;
            r_strobe     <= n_strobe;
            r_g1         <= n_g1;
            r_g2         <= n_g2;
            r_thr        <= n_thr;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_first_ink  <= n_first_ink;
        r_col        <= n_col;
        r_first      <= n_first;
        r_endc       <= n_endc;
        r_space      <= n_space;
        r_pend_start <= n_pend_start;
        r_pend_end   <= n_pend_end;
        r_out_start  <= n_out_start;
        r_out_end    <= n_out_end;
        r_out_last   <= n_out_last;
        r_out_noink  <= n_out_noink;
        r_out_ovf    <= n_out_ovf;
    end

    assign o_strobe      = r_strobe;
    assign o_seg_start   = r_out_start;
    assign o_seg_end     = r_out_end;
    assign o_last_result = r_out_last;
    assign o_no_ink      = r_out_noink;
    assign o_overflow    = r_out_ovf;

endmodule

// ===== sv/word_gap_segmenter.sv =====
// Top level of the word gap segmenter: controller plus datapath.
//
// Usage: one column flag per transfer on i_column_has_ink, taken at an edge where
// start is high and busy is low; i_last_column marks the final column of a line.
// Columns are taken back to back, one per cycle, while the line is loaded, and the
// gap threshold is estimated on the fly during loading. Columns beyond MAX_WIDTH
// are dropped, but their last-column mark still ends the line.
// After the last column, busy stays high while the stored columns from the first
// inked column on are scanned, and then while the final result is given out; one
// column of the line store is scanned per cycle through its single registered read
// port. A line without ink gives a single result with o_no_ink set.
// Each word appears on the o_seg_* ports for one cycle with o_strobe high; the
// final result of a line has o_last_result set, and o_overflow when words beyond
// MAX_SEGMENTS were dropped. The receiver cannot stall; results are not held.
// i_cfg_we writes probe_ratio from i_cfg_data; write it only while idle.
// Synchronous reset clears the controller, the column count and sets probe_ratio
// to 3; the line store itself is not cleared.
module word_gap_segmenter #(
    parameter int MAX_WIDTH    = wgs_pkg::WGS_MAX_WIDTH,
    parameter int MAX_SEGMENTS = wgs_pkg::WGS_MAX_SEGMENTS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_column_has_ink,
    input  logic                        i_last_column,
    input  logic                        i_cfg_we,
    input  logic [wgs_pkg::PROBE_W-1:0] i_cfg_data,
    output logic                        o_strobe,
    output logic [wgs_pkg::START_W-1:0] o_seg_start,
    output logic [wgs_pkg::END_W-1:0]   o_seg_end,
    output logic                        o_last_result,
    output logic                        o_no_ink,
    output logic                        o_overflow
);

    import wgs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencing of load, scan and result phases.
    wgs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_last_column(i_last_column),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .busy         (busy)
    );

    // Storage, estimation and word scan.
    wgs_dp #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_column_has_ink(i_column_has_ink),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_seg_start     (o_seg_start),
        .o_seg_end       (o_seg_end),
        .o_last_result   (o_last_result),
        .o_no_ink        (o_no_ink),
        .o_overflow      (o_overflow)
    );

endmodule
